[src/tpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tpm_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int WINDOW_DEPTH      = 2 * MAX_PATTERN_BYTES;
  localparam int OFFSET_BITS       = 32;
  localparam int COUNT_BITS        = 32;
  localparam int CFG_DATA_BITS     = 64;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int PATTERN_WORDS     = MAX_PATTERN_BYTES / 8;
  localparam int LEN_BITS          = 6;
  localparam int SPAN_BITS         = LEN_BITS + 1;
  localparam int PAT_IDX_BITS      = $clog2(MAX_PATTERN_BYTES);

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_0      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_3      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CASE_FOLD      = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE_MODE      = 3'd6;

  localparam logic [OFFSET_BITS-1:0] POSITION_MAX = '1;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = '1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_blob;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_offset;
    logic [31:0] match_count;
    logic [31:0] first_offset;
    logic        found;
  } out_item_t;

  typedef struct packed {
    logic [MAX_PATTERN_BYTES-1:0][7:0] pattern;
    logic [LEN_BITS-1:0]               pattern_length;
    logic                              case_fold;
    logic                              wide_mode;
  } cfg_t;

  // Pattern laid out against the byte window, index 0 = newest byte
  typedef struct packed {
    logic [WINDOW_DEPTH-1:0][7:0] expect_byte;
    logic [WINDOW_DEPTH-1:0]      care;
    logic [WINDOW_DEPTH-1:0]      zero_req;
    logic [SPAN_BITS-1:0]         span;
    logic                         enable;
  } align_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c inside {[8'h41:8'h5A]})) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/tpm_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tpm_in_if;
  logic              valid;
  logic              ready;
  tpm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpm_out_if;
  logic               valid;
  logic               ready;
  tpm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/tpm_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpm_cfg_regs (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [tpm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [tpm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output tpm_pkg::cfg_t                               cfg
);
  import tpm_pkg::*;

  logic [PATTERN_WORDS-1:0][CFG_DATA_BITS-1:0] pattern_reg;
  logic [LEN_BITS-1:0]                         pattern_length;
  logic                                        case_fold;
  logic                                        wide_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_reg    <= '0;
      pattern_length <= '0;
      case_fold      <= 1'b0;
      wide_mode      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index) inside
        [REG_PATTERN_0:REG_PATTERN_3]: begin
          pattern_reg[cfg_index[$clog2(PATTERN_WORDS)-1:0]] <= cfg_data;
        end
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_BITS-1:0];
        REG_CASE_FOLD:      case_fold      <= cfg_data[0];
        REG_WIDE_MODE:      wide_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.pattern        = pattern_reg;
    cfg.pattern_length = pattern_length;
    cfg.case_fold      = case_fold;
    cfg.wide_mode      = wide_mode;
  end

endmodule

`default_nettype wire

[src/tpm_align.sv]
`timescale 1ns / 1ps
`default_nettype none

// Places each (folded) pattern byte at the window slot it must meet when
// the match ends at the newest byte. Depends on configuration only.
module tpm_align (
  input  wire tpm_pkg::cfg_t cfg,
  output tpm_pkg::align_t    align
);
  import tpm_pkg::*;

  logic [SPAN_BITS-1:0] span;
  logic [SPAN_BITS-1:0] idx;
  logic [PAT_IDX_BITS-1:0] j;

  always_comb begin
    span = cfg.wide_mode ? {cfg.pattern_length, 1'b0} : {1'b0, cfg.pattern_length};
    align.span   = span;
    align.enable = (cfg.pattern_length != '0) &&
                   ({1'b0, cfg.pattern_length} <= SPAN_BITS'(MAX_PATTERN_BYTES));
    idx = '0;
    j   = '0;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      idx = span - SPAN_BITS'(1) - SPAN_BITS'(k);
      align.care[k] = SPAN_BITS'(k) < span;
      if (cfg.wide_mode) begin
        align.zero_req[k] = idx[0];
        j = idx[PAT_IDX_BITS:1];
      end else begin
        align.zero_req[k] = 1'b0;
        j = idx[PAT_IDX_BITS-1:0];
      end
      align.expect_byte[k] = fold_byte(cfg.pattern[j], cfg.case_fold);
    end
  end

endmodule

`default_nettype wire

[src/tpm_match.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpm_match (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire tpm_pkg::in_item_t item,
  input  wire logic             advance,
  input  wire logic             case_fold,
  input  wire tpm_pkg::align_t  align,
  output logic                  out_valid,
  output tpm_pkg::out_item_t    out_item
);
  import tpm_pkg::*;

  logic [WINDOW_DEPTH-1:0][7:0] window;
  logic [WINDOW_DEPTH-1:0][7:0] window_next;
  logic [OFFSET_BITS-1:0]       position;
  logic [COUNT_BITS-1:0]        running_count;
  logic [COUNT_BITS-1:0]        count_next;
  logic [OFFSET_BITS-1:0]       first_match_offset;
  logic [OFFSET_BITS-1:0]       first_next;
  logic                         any_match_seen;
  logic                         found_next;
  logic [WINDOW_DEPTH-1:0]      slot_ok;
  logic [SPAN_BITS-1:0]         span_m1;
  logic [OFFSET_BITS-1:0]       start;
  logic                         hit;
  logic                         fire;

  assign fire = item_valid && advance;

  always_comb begin
    window_next[0] = item.data_byte;
    for (int k = 1; k < WINDOW_DEPTH; k++) begin
      window_next[k] = window[k-1];
    end
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      if (!align.care[k]) begin
        slot_ok[k] = 1'b1;
      end else if (align.zero_req[k]) begin
        slot_ok[k] = (window_next[k] == 8'h00);
      end else begin
        slot_ok[k] = (fold_byte(window_next[k], case_fold) == align.expect_byte[k]);
      end
    end
    span_m1 = align.span - SPAN_BITS'(1);
    start   = position - OFFSET_BITS'(span_m1);
    hit     = align.enable && (&slot_ok) && (position >= OFFSET_BITS'(span_m1));

    count_next = running_count;
    first_next = first_match_offset;
    found_next = any_match_seen;
    if (hit) begin
      if (!any_match_seen) begin
        found_next = 1'b1;
        first_next = start;
      end
      if (running_count != COUNT_MAX) begin
        count_next = running_count + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window             <= '0;
      position           <= '0;
      running_count      <= '0;
      first_match_offset <= '0;
      any_match_seen     <= 1'b0;
    end else if (fire) begin
      if (item.last_of_blob) begin
        window             <= '0;
        position           <= '0;
        running_count      <= '0;
        first_match_offset <= '0;
        any_match_seen     <= 1'b0;
      end else begin
        window             <= window_next;
        running_count      <= count_next;
        first_match_offset <= first_next;
        any_match_seen     <= found_next;
        if (position != POSITION_MAX) begin
          position <= position + OFFSET_BITS'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.hit          <= hit;
      out_item.hit_offset   <= hit ? start[31:0] : 32'd0;
      out_item.match_count  <= count_next;
      out_item.first_offset <= found_next ? first_next[31:0] : 32'd0;
      out_item.found        <= found_next;
    end
  end

endmodule

`default_nettype wire

[src/text_pattern_match_counter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Payload                                         | Handshake
// in_ch    | in        | data_byte, last_of_blob                         | valid/ready
// out_ch   | out       | hit, hit_offset, match_count, first_offset, found | valid/ready
// cfg      | in        | cfg_index, cfg_data                             | cfg_we, no wait
//
// One byte per cycle sustained while the output is not stalled; each byte's result
// passes the input register, then the window compare into the result register.
// The compare of all 64 window slots against the aligned pattern is the path
// that sets the clock.
// rst is synchronous: clears configuration, window and counters.
// A stalled output holds both registers; input ready drops only when both are full.
module text_pattern_match_counter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  tpm_in_if.sink                                  in_ch,
  tpm_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [tpm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tpm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tpm_pkg::*;

  cfg_t      cfg;
  align_t    align;
  in_item_t  item;
  logic      item_valid;
  logic      advance;
  logic      out_valid;
  out_item_t out_item;

  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item <= in_ch.data;
    end
  end

  tpm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpm_align u_align (
    .cfg   (cfg),
    .align (align)
  );

  tpm_match u_match (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .case_fold  (cfg.case_fold),
    .align      (align),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

endmodule

`default_nettype wire

[src/tpm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire tpm_pkg::out_item_t out_data
);

  // a waiting result must not drop
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> out_data.found && (out_data.match_count != 32'd0))
    else $error("hit without found flag or count");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> (out_data.match_count == 32'd0) &&
                                     (out_data.first_offset == 32'd0))
    else $error("count or first offset set before any match");

  // first offset never lies after the start of the current match
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> out_data.first_offset <= out_data.hit_offset)
    else $error("first offset after current match");

endmodule

bind text_pattern_match_counter tpm_checker u_tpm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
